// File: src/csoba_pkg.sv
// ----------------------------------------------------------------------------
// csoba_pkg: shared types and constants
// Widths, register map, job descriptor and reset values for the offset
// calibration / block average datapath.
// ----------------------------------------------------------------------------
package csoba_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int MAX_BLOCK      = 4096;
  localparam int SPB_BITS       = 13;
  localparam int OFS_BITS       = 16;
  localparam int GAIN_BITS      = 32;
  localparam int BLOCK_POS_BITS = 13;
  localparam int BLOCK_ACC_BITS = 24;
  localparam int OFF_ACC_BITS   = 28;
  localparam int OFF_CNT_BITS   = 17;

  // divider: quotient is always a sample-wide mean
  localparam int DIVIDEND_BITS  = OFF_ACC_BITS;
  localparam int DIVISOR_BITS   = OFF_CNT_BITS;
  localparam int QUO_BITS       = SAMPLE_BITS;
  localparam int DIV_CNT_BITS   = $clog2(QUO_BITS);

  localparam int AMPS_BITS      = 32;
  localparam int PROD_BITS      = SAMPLE_BITS + 1 + GAIN_BITS + 1;
  localparam int SHIFT_Q        = 8;
  localparam int MAG_BITS       = PROD_BITS - SHIFT_Q;

  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 64;

  localparam int QDEPTH         = 4;
  localparam int QPTR_BITS      = $clog2(QDEPTH);
  localparam int QCNT_BITS      = $clog2(QDEPTH + 1);

  localparam int PADDR_BITS     = 4;

  localparam logic [SPB_BITS-1:0]  SPB_RESET  = SPB_BITS'(256);
  localparam logic [OFS_BITS-1:0]  OFS_RESET  = OFS_BITS'(1024);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(13520);

  typedef enum logic [1:0] {
    REG_SPB  = 2'd0,
    REG_OFS  = 2'd1,
    REG_GAIN = 2'd2
  } reg_idx_t;

  typedef enum logic {
    JOB_OFFSET = 1'b0,
    JOB_BLOCK  = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t                kind;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVISOR_BITS-1:0]  divisor;
  } job_t;

  typedef struct packed {
    logic [SPB_BITS-1:0] samples_per_block;
    logic [OFS_BITS-1:0] offset_samples;
  } front_cfg_t;

endpackage

// File: src/csoba_front.sv
// ----------------------------------------------------------------------------
// csoba_front: sample intake
// Accumulates the offset estimate and block sums, tracks block position and
// issues divide jobs at offset completion and at the end of measuring blocks.
// ----------------------------------------------------------------------------
module csoba_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csoba_pkg::front_cfg_t                cfg,
  input  logic                                 accept,
  input  logic [csoba_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                 push,
  output csoba_pkg::job_t                      job
);
  import csoba_pkg::*;

  logic                      offset_done;
  logic [OFF_ACC_BITS-1:0]   offset_accumulator;
  logic [OFF_CNT_BITS-1:0]   offset_sample_count;
  logic [BLOCK_ACC_BITS-1:0] block_accumulator;
  logic [BLOCK_POS_BITS-1:0] block_position;
  logic                      block_live;

  logic                      live;
  logic [BLOCK_ACC_BITS-1:0] acc_base;
  logic [BLOCK_ACC_BITS-1:0] block_acc_next;
  logic [OFF_ACC_BITS-1:0]   off_acc_next;
  logic [OFF_CNT_BITS-1:0]   off_cnt_next;
  logic [BLOCK_POS_BITS-1:0] pos_next;
  logic [SPB_BITS-1:0]       blen;
  logic [OFS_BITS-1:0]       olen;
  logic                      block_end;
  logic                      offset_end;

  always_comb begin
    if (cfg.samples_per_block == '0) begin
      blen = SPB_BITS'(1);
    end else if (cfg.samples_per_block > SPB_BITS'(MAX_BLOCK)) begin
      blen = SPB_BITS'(MAX_BLOCK);
    end else begin
      blen = cfg.samples_per_block;
    end
    olen = (cfg.offset_samples == '0) ? OFS_BITS'(1) : cfg.offset_samples;
  end

  always_comb begin
    live           = (block_position == '0) ? offset_done : block_live;
    acc_base       = (block_position == '0) ? '0 : block_accumulator;
    block_acc_next = acc_base + BLOCK_ACC_BITS'(sample);
    off_acc_next   = offset_accumulator + OFF_ACC_BITS'(sample);
    off_cnt_next   = offset_sample_count + OFF_CNT_BITS'(1);
    pos_next       = block_position + BLOCK_POS_BITS'(1);
    offset_end     = !live && !offset_done && (off_cnt_next >= OFF_CNT_BITS'(olen));
    block_end      = pos_next >= blen;
  end

  always_comb begin
    push = accept && (offset_end || (block_end && live));
    if (offset_end) begin
      job.kind     = JOB_OFFSET;
      job.dividend = off_acc_next;
      job.divisor  = off_cnt_next;
    end else begin
      job.kind     = JOB_BLOCK;
      job.dividend = DIVIDEND_BITS'(block_acc_next);
      job.divisor  = DIVISOR_BITS'(pos_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_done         <= 1'b0;
      offset_accumulator  <= '0;
      offset_sample_count <= '0;
      block_accumulator   <= '0;
      block_position      <= '0;
      block_live          <= 1'b0;
    end else if (accept) begin
      block_live        <= live;
      block_accumulator <= live ? block_acc_next : acc_base;
      if (!live && !offset_done) begin
        offset_accumulator  <= off_acc_next;
        offset_sample_count <= off_cnt_next;
        if (offset_end) begin
          offset_done <= 1'b1;
        end
      end
      block_position <= block_end ? '0 : pos_next;
    end
  end

endmodule

// File: src/csoba_queue.sv
// ----------------------------------------------------------------------------
// csoba_queue: job queue
// Small FIFO of divide jobs between intake and arithmetic.
// ----------------------------------------------------------------------------
module csoba_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csoba_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output csoba_pkg::job_t head
);
  import csoba_pkg::*;

  job_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = count == QCNT_BITS'(QDEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/csoba_back.sv
// ----------------------------------------------------------------------------
// csoba_back: divide, scale and saturate
// Serial restoring divider for offset and block means, then offset
// subtraction, gain multiply, Q16.16 saturation and the output register.
// ----------------------------------------------------------------------------
module csoba_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [csoba_pkg::GAIN_BITS-1:0]         gain,
  input  logic                                    q_valid,
  input  csoba_pkg::job_t                         q_head,
  output logic                                    q_pop,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [csoba_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);
  import csoba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                   state;
  job_kind_t                kind;
  logic [DIVIDEND_BITS-1:0] rem;
  logic [DIVIDEND_BITS-1:0] dsh;
  logic [QUO_BITS-1:0]      quo;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [SAMPLE_BITS-1:0]   offset_value;
  logic [SAMPLE_BITS-1:0]   avg;
  logic signed [PROD_BITS-1:0] prod;

  logic                     ge;
  logic [QUO_BITS-1:0]      quo_next;
  logic signed [SAMPLE_BITS:0] diff;
  logic [PROD_BITS-1:0]     abs_prod;
  logic [MAG_BITS-1:0]      mag;
  logic [AMPS_BITS-1:0]     amps;
  logic                     sat;
  logic                     load_out;

  assign ge       = rem >= dsh;
  assign quo_next = {quo[QUO_BITS-2:0], ge};
  assign diff     = $signed({1'b0, avg}) - $signed({1'b0, offset_value});
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_OUT) && (!m_tvalid || m_tready);

  // truncate toward zero: shift the magnitude, then restore the sign
  always_comb begin
    abs_prod = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    mag      = abs_prod[PROD_BITS-1:SHIFT_Q];
    sat      = 1'b0;
    if (prod[PROD_BITS-1]) begin
      if (mag > MAG_BITS'(64'h8000_0000)) begin
        amps = 32'h8000_0000;
        sat  = 1'b1;
      end else begin
        amps = -mag[AMPS_BITS-1:0];
      end
    end else begin
      if (mag > MAG_BITS'(64'h7FFF_FFFF)) begin
        amps = 32'h7FFF_FFFF;
        sat  = 1'b1;
      end else begin
        amps = mag[AMPS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      offset_value <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            if (kind == JOB_OFFSET) begin
              offset_value <= quo_next;
              state        <= S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        kind <= q_head.kind;
        rem  <= q_head.dividend;
        dsh  <= DIVIDEND_BITS'({q_head.divisor, {(QUO_BITS-1){1'b0}}});
        quo  <= '0;
        cnt  <= DIV_CNT_BITS'(QUO_BITS - 1);
      end
      S_DIV: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - DIV_CNT_BITS'(1);
        avg <= quo_next;
      end
      S_MUL: prod <= PROD_BITS'(diff * $signed({1'b0, gain}));
      default: begin
      end
    endcase
    if (load_out) begin
      m_tdata <= {7'd0, sat, offset_value, avg, amps};
    end
  end

  a_out_is_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (kind == JOB_BLOCK))
    else $error("output stage reached for an offset job");

  a_offset_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == '0 && kind == JOB_OFFSET) |=> (state == S_IDLE))
    else $error("offset job did not finish in idle");

  a_sat_clips: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[56]) |->
      (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000))
    else $error("saturation flag without clipped value");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_DIV))
    else $error("popped job not started");

endmodule

// File: src/current_sense_offset_block_average.sv
// ----------------------------------------------------------------------------
// current_sense_offset_block_average: ADC current offset and block averaging
// Offset calibration after reset, then one scaled Q16.16 current per block.
// ----------------------------------------------------------------------------
// Takes one 12-bit ADC word per cycle while s_tready is high. After reset the
// first offset_samples words are averaged into the zero-current offset; the
// rest of that block is dropped. Each later block of samples_per_block words
// gives one word at m_tdata: (mean - offset) * gain / 256 as signed Q16.16,
// truncated toward zero and clipped to 32 bits. Intake runs at one word per
// cycle, while each offset or block job passes through the back part (a
// 12-step serial divider, one multiply, one output stage), and a
// 4-entry job queue between the two parts absorbs them. With blocks that end
// faster than jobs drain, or a stalled m_tready, the queue fills and s_tready
// drops until a job drains. No clearing pass after reset. Registers
// (APB, pready always high): 0x0 samples_per_block, 0x4 offset_samples,
// 0x8 gain (unsigned Q8.24); write them only while the block is idle.
// ----------------------------------------------------------------------------
module current_sense_offset_block_average (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata: [11:0] sample, [15:12] zero
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [csoba_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  // m_tdata: [31:0] current_amps, [43:32] block_average,
  //          [55:44] offset_counts, [56] saturated, [63:57] zero
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [csoba_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csoba_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import csoba_pkg::*;

  logic [SPB_BITS-1:0]  samples_per_block;
  logic [OFS_BITS-1:0]  offset_samples;
  logic [GAIN_BITS-1:0] gain;

  front_cfg_t fcfg;
  logic       accept;
  logic       push;
  job_t       push_job;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  job_t       q_head;
  reg_idx_t   widx;
  logic       wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // config registers; index 3 is unmapped
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_block <= SPB_RESET;
      offset_samples    <= OFS_RESET;
      gain              <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (widx)
        REG_SPB:  samples_per_block <= pwdata[SPB_BITS-1:0];
        REG_OFS:  offset_samples    <= pwdata[OFS_BITS-1:0];
        REG_GAIN: gain              <= pwdata[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SPB:  prdata = 32'(samples_per_block);
      REG_OFS:  prdata = 32'(offset_samples);
      REG_GAIN: prdata = gain;
      default:  prdata = '0;
    endcase
  end

  // a word may cause a job, so take it only with room in the queue
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign fcfg     = '{samples_per_block: samples_per_block,
                      offset_samples:    offset_samples};

  csoba_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (fcfg),
    .accept (accept),
    .sample (s_tdata[SAMPLE_BITS-1:0]),
    .push   (push),
    .job    (push_job)
  );

  csoba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  csoba_back u_back (
    .clk      (clk),
    .rst      (rst),
    .gain     (gain),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: bench/current_sense_offset_block_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_sense_offset_block_average_tb: self-checking bench
// Streams ADC words into the offset/block-average block, models the offset
// capture and per-block scaling cycle by word, and checks every m_tdata word.
// ----------------------------------------------------------------------------
module current_sense_offset_block_average_tb;
  import csoba_pkg::*;

  localparam int CLK_HALF               = 5;
  localparam int RESET_CYCLES           = 12;
  // back part: settle time to finish up to 4 queued jobs that may give no word
  localparam int SETTLE_CYCLES          = 80;
  localparam int CYCLE_LIMIT            = 1_000_000;
  localparam int RANDOM_WORDS_PER_PHASE = 120;
  localparam int MIN_READINGS_PER_PHASE = 4;
  localparam int SAMPLE_MAX             = (1 << SAMPLE_BITS) - 1;
  localparam int NUM_PHASES             = 4;

  // how the words of one random burst are filled
  typedef enum logic [1:0] {
    FILL_RANDOM      = 2'd0,
    FILL_FLAT        = 2'd1,
    FILL_NEAR_OFFSET = 2'd2,
    FILL_RAILS       = 2'd3
  } fill_t;

  // one expected output word, split into its fields
  typedef struct {
    logic [AMPS_BITS-1:0]   amps;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] offset;
    logic                   sat;
  } reading_t;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [PADDR_BITS-1:0]     paddr    = '0;
  logic [31:0]               pwdata   = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // register copies as the block should hold them
  logic [SPB_BITS-1:0]       cfg_block_size = SPB_RESET;
  logic [OFS_BITS-1:0]       cfg_offset_len = OFS_RESET;
  logic [GAIN_BITS-1:0]      cfg_gain       = GAIN_RESET;

  // offset capture and block averaging state
  bit                        offset_known   = 1'b0;
  longint unsigned           offset_total   = 0;
  int unsigned               offset_seen    = 0;
  logic [SAMPLE_BITS-1:0]    offset_counts  = '0;
  longint unsigned           block_sum      = 0;
  int unsigned               block_pos      = 0;
  bit                        block_live     = 1'b0;

  reading_t                  expected_readings[$];
  int unsigned               words_sent     = 0;
  int unsigned               readings_seen  = 0;
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count    = 0;
  int unsigned               send_idle_pct  = 0;
  int unsigned               recv_stall_pct = 0;

  current_sense_offset_block_average i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // hard stop in case a word never shows up or s_tready sticks low
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL current_sense_offset_block_average");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model --

  // block length after clamping: zero acts as one, capped at MAX_BLOCK
  function automatic int unsigned measure_len();
    int unsigned n;
    n = cfg_block_size;
    if (n == 0) n = 1;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    return n;
  endfunction

  function automatic int unsigned offset_target();
    return (cfg_offset_len == 0) ? 1 : cfg_offset_len;
  endfunction

  // Advance the model by one accepted word; queue a reading at a live block end.
  task automatic predict_current(input logic [SAMPLE_BITS-1:0] smp);
    int unsigned            taken;
    logic [SAMPLE_BITS-1:0] mean;
    longint                 diff;
    longint                 prod;
    longint unsigned        mag;
    reading_t               r;
    // a block only measures if the offset was known when it started
    if (block_pos == 0) begin
      block_live = offset_known;
      block_sum  = 0;
    end
    if (block_live) begin
      block_sum += smp;
    end else if (!offset_known) begin
      offset_total += smp;
      offset_seen  += 1;
      if (offset_seen >= offset_target()) begin
        offset_counts = SAMPLE_BITS'(offset_total / offset_seen);
        offset_known  = 1'b1;
      end
    end
    // words after capture in a non-live block are dropped
    block_pos += 1;
    if (block_pos < measure_len()) return;
    // position may exceed a freshly lowered length: divide by words taken
    taken     = block_pos;
    block_pos = 0;
    if (!block_live) return;
    mean = SAMPLE_BITS'(block_sum / taken);
    diff = longint'(mean) - longint'(offset_counts);
    prod = diff * longint'(cfg_gain);
    // Q8.24 gain to Q16.16: drop 8 bits on the magnitude (toward zero)
    mag  = (prod < 0 ? -prod : prod) >> SHIFT_Q;
    r.sat = 1'b0;
    if (prod < 0) begin
      if (mag > 64'd2147483648) begin
        mag   = 64'd2147483648;
        r.sat = 1'b1;
      end
      r.amps = AMPS_BITS'(-longint'(mag));
    end else begin
      if (mag > 64'd2147483647) begin
        mag   = 64'd2147483647;
        r.sat = 1'b1;
      end
      r.amps = AMPS_BITS'(mag);
    end
    r.mean   = mean;
    r.offset = offset_counts;
    expected_readings.push_back(r);
  endtask

  // ------------------------------------------------------------- drivers --

  // APB write: setup phase, access phase, then an idle phase
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SPB:  cfg_block_size = value[SPB_BITS-1:0];
      REG_OFS:  cfg_offset_len = value[OFS_BITS-1:0];
      REG_GAIN: cfg_gain       = value[GAIN_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One word on the slave side. s_tvalid stays high unless a gap is drawn,
  // so back-to-back words never lower and raise it in one step.
  task automatic send_word(input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_BITS'(smp);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_current(smp);
    words_sent++;
  endtask

  // Hold the sender until every reading is out, then let the back part
  // finish jobs that give no word (offset, dropped blocks).
  task automatic wait_readings_drained();
    s_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------- checker --

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_reading(input logic [OUT_TDATA_BITS-1:0] word);
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("word %h with no reading pending", word));
      return;
    end
    want = expected_readings.pop_front();
    readings_seen++;
    if (word[31:0] !== want.amps)
      report_mismatch($sformatf("current_amps %h, want %h", word[31:0], want.amps));
    if (word[43:32] !== want.mean)
      report_mismatch($sformatf("block_average %h, want %h", word[43:32], want.mean));
    if (word[55:44] !== want.offset)
      report_mismatch($sformatf("offset_counts %h, want %h", word[55:44], want.offset));
    if (word[56] !== want.sat)
      report_mismatch($sformatf("saturated %b, want %b", word[56], want.sat));
    if (word[63:57] !== '0)
      report_mismatch($sformatf("pad bits %h, want zero", word[63:57]));
  endtask

  // master side: check on handshake, redraw m_tready every cycle
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_reading(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------- tests --

  // Offset capture over 4-word blocks. Zero count takes the first word;
  // 6 spans a silent block and ends mid-block; 8 ends on a block edge.
  task automatic test_offset_capture();
    logic [31:0] target;
    case ($urandom_range(2))
      0:       target = 32'd0;
      1:       target = 32'd6;
      default: target = 32'd8;
    endcase
    apb_write(REG_SPB, 32'd4);
    apb_write(REG_OFS, target);
    repeat (8) send_word(SAMPLE_BITS'($urandom_range(2300, 1800)));
    // first block that starts after capture measures, at the reset gain
    repeat (4) send_word(SAMPLE_BITS'(SAMPLE_MAX));
  endtask

  // One-word blocks so each word is a reading; gain and clip corners.
  task automatic test_scaling_extremes();
    wait_readings_drained();
    apb_write(REG_SPB, 32'd1);
    apb_write(REG_GAIN, 32'hFFFF_FFFF);
    send_word(SAMPLE_BITS'(SAMPLE_MAX));   // clips high
    send_word('0);                         // clips low
    send_word(offset_counts);              // zero current
    wait_readings_drained();
    // 256 counts at 2^31 lands exactly on -2^31 (no clip) and 2^31 (clip)
    apb_write(REG_GAIN, 32'h8000_0000);
    send_word(offset_counts - SAMPLE_BITS'(256));
    send_word(offset_counts + SAMPLE_BITS'(256));
    wait_readings_drained();
    apb_write(REG_GAIN, 32'd0);
    send_word(SAMPLE_BITS'(SAMPLE_MAX));
    wait_readings_drained();
    // tiny gain: negative products truncate toward zero
    apb_write(REG_GAIN, 32'd1);
    send_word('0);
    send_word(SAMPLE_BITS'(SAMPLE_MAX));
  endtask

  // Block length zero, a length cut below the fill level, and the top clamp.
  task automatic test_block_size_edges();
    wait_readings_drained();
    apb_write(REG_GAIN, GAIN_RESET);
    apb_write(REG_SPB, 32'd0);
    repeat (2) send_word(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
    wait_readings_drained();
    apb_write(REG_SPB, 32'd8);
    repeat (5) send_word(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
    wait_readings_drained();
    // already 5 in: the next word closes a 6-word block
    apb_write(REG_SPB, 32'd2);
    send_word(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
    wait_readings_drained();
    // largest register value clamps to MAX_BLOCK, so no block ends early
    apb_write(REG_SPB, 32'h1FFF);
    repeat (40) send_word(SAMPLE_BITS'(SAMPLE_MAX));
    wait_readings_drained();
    // cut the long block short: the next word closes it at 41 words
    apb_write(REG_SPB, 32'd2);
    send_word(SAMPLE_BITS'(SAMPLE_MAX));
  endtask

  // A later offset_samples write must not restart capture.
  task automatic test_late_offset_write();
    wait_readings_drained();
    apb_write(REG_OFS, 32'hFFFF);
    apb_write(REG_SPB, 32'd32);
    repeat (64) send_word(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
  endtask

  // Random bursts under four idle/stall mixes; settings change between
  // bursts, often mid-block, with each burst filled in one style.
  task automatic test_random_traffic();
    int unsigned pct_send [NUM_PHASES] = '{0, 85, 0, 13};
    int unsigned pct_stall[NUM_PHASES] = '{0, 0, 85, 13};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int unsigned words_at_start;
      int unsigned readings_at_start;
      int unsigned len;
      int unsigned count;
      int unsigned base;
      int          v;
      fill_t       fill;
      logic [31:0] spb;
      logic [31:0] g;
      send_idle_pct     = pct_send[ph];
      recv_stall_pct    = pct_stall[ph];
      words_at_start    = words_sent;
      readings_at_start = readings_seen;
      while (words_sent - words_at_start < RANDOM_WORDS_PER_PHASE ||
             readings_seen - readings_at_start < MIN_READINGS_PER_PHASE) begin
        wait_readings_drained();
        // mostly short blocks, now and then one word per block
        case ($urandom_range(9))
          0:       spb = $urandom_range(1);
          1, 2, 3: spb = $urandom_range(31, 2);
          9:       spb = $urandom_range(300, 97);
          default: spb = $urandom_range(96, 32);
        endcase
        case ($urandom_range(5))
          0:       g = '0;
          1:       g = '1;
          2:       g = GAIN_RESET;
          3:       g = $urandom_range(1 << 20);
          default: g = $urandom();
        endcase
        apb_write(REG_SPB, spb);
        apb_write(REG_GAIN, g);
        if ($urandom_range(3) == 0) apb_write(REG_OFS, $urandom());
        len   = measure_len();
        count = $urandom_range(3 * len, len);
        fill  = fill_t'($urandom_range(3));
        base  = $urandom_range(SAMPLE_MAX);
        repeat (count) begin
          case (fill)
            FILL_FLAT:        v = base;
            FILL_NEAR_OFFSET: v = int'(offset_counts) + int'($urandom_range(32)) - 16;
            FILL_RAILS:       v = $urandom_range(1) ? SAMPLE_MAX : 0;
            default:          v = $urandom_range(SAMPLE_MAX);
          endcase
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          send_word(SAMPLE_BITS'(v));
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_offset_capture();
    test_scaling_extremes();
    test_block_size_edges();
    test_late_offset_write();
    test_random_traffic();
    wait_readings_drained();
    if (mismatch_count == 0) begin
      $display("PASS current_sense_offset_block_average");
    end else begin
      $display("FAIL current_sense_offset_block_average");
    end
    $finish;
  end

endmodule
